[hdl/gsck_pkg.sv]
package gsck_pkg;

   localparam int GRID_N  = 8;
   localparam int ORIENTS = 8;
   localparam int CELL_W  = 2;
   localparam int ROW_W   = GRID_N * CELL_W;
   localparam int IDX_W   = 3;

   // cell codes
   localparam logic [CELL_W-1:0] CELL_EMPTY   = 2'd0;
   localparam logic [CELL_W-1:0] CELL_BLOCKED = 2'd3;

   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [ROW_W-1:0]  row_type;
   // row 0 sits in the most significant bits, so a plain unsigned compare
   // of two keys is the row-0-first lexicographic order
   typedef logic [0:GRID_N-1][ROW_W-1:0] key_type;

   // orientation k: source row = BASE_R + i*STEP_RI + j*STEP_RJ,
   //                source col = BASE_C + i*STEP_CI + j*STEP_CJ
   localparam int BASE_R  [ORIENTS] = '{0, 0, 0, 0, 7, 7, 7, 7};
   localparam int BASE_C  [ORIENTS] = '{0, 0, 7, 7, 7, 7, 0, 0};
   localparam int STEP_RJ [ORIENTS] = '{0, 1, 1, 0, 0, -1, -1, 0};
   localparam int STEP_RI [ORIENTS] = '{1, 0, 0, 1, -1, 0, 0, -1};
   localparam int STEP_CJ [ORIENTS] = '{1, 0, 0, -1, -1, 0, 0, 1};
   localparam int STEP_CI [ORIENTS] = '{0, 1, -1, 0, 0, -1, 1, 0};

   // blocked cells read empty; the second side swaps codes 1 and 2
   function automatic cell_type norm_cell(cell_type v, logic swap);
      cell_type r;
      if (v == CELL_BLOCKED) begin
         r = CELL_EMPTY;
      end else if (swap && (v != CELL_EMPTY)) begin
         r = ~v;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // source {row, col} of canonical cell (i, j) under orientation k
   function automatic logic [2*IDX_W-1:0] src_index(int k, int i, int j);
      int gr;
      int gc;
      gr = (BASE_R[k] + i * STEP_RI[k] + j * STEP_RJ[k]) & (GRID_N - 1);
      gc = (BASE_C[k] + i * STEP_CI[k] + j * STEP_CJ[k]) & (GRID_N - 1);
      return {IDX_W'(gr), IDX_W'(gc)};
   endfunction

endpackage

[hdl/grid_symmetry_canonical_key_top.sv]
// Canonical key of an 8x8 grid of 2-bit cells under its eight rotations and
// reflections.
// Input channel req_: one word is the side bit and eight 16-bit rows; it is
// taken at a rising edge with req_valid high and req_stall low.
// Result channel rsp_: one word per input, the 128-bit key split into
// rsp_key_low (rows 0-3) and rsp_key_high (rows 4-7), taken at a rising
// edge with rsp_valid high and rsp_stall low.
// Throughput: one word per cycle while the receiver does not stall. The work
// is an input register, a stage that builds the eight orientations and keeps
// the larger of each pair, then two more max-of-pairs stages, the last one
// being the output register. Each max-of-pairs stage is one 128-bit compare
// deep.
// Reset clears all valid flags; nothing else needs clearing. When the
// receiver stalls, the result holds and stages behind it keep filling
// empty slots; req_stall rises only once every stage holds a word.
module grid_symmetry_canonical_key_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_side_is_second,
   input  logic [15:0] req_row_0,
   input  logic [15:0] req_row_1,
   input  logic [15:0] req_row_2,
   input  logic [15:0] req_row_3,
   input  logic [15:0] req_row_4,
   input  logic [15:0] req_row_5,
   input  logic [15:0] req_row_6,
   input  logic [15:0] req_row_7,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_key_low,
   output logic [63:0] rsp_key_high
);

   localparam int N = gsck_pkg::ORIENTS;

   logic              in_valid_ff;
   logic              in_side_ff;
   gsck_pkg::row_type in_rows_ff [gsck_pkg::GRID_N];
   gsck_pkg::row_type in_rows_in [gsck_pkg::GRID_N];

   gsck_pkg::key_type cand [N];
   gsck_pkg::key_type lvl1 [N/2];
   gsck_pkg::key_type lvl2 [N/4];
   gsck_pkg::key_type best [1];
   logic              lvl1_valid;
   logic              lvl2_valid;
   logic              adv_in;
   logic              adv1;
   logic              adv2;
   logic              adv3;

   // each slot loads when empty or when its word moves on
   assign adv3      = !rsp_valid || !rsp_stall;
   assign adv2      = !lvl2_valid || adv3;
   assign adv1      = !lvl1_valid || adv2;
   assign adv_in    = !in_valid_ff || adv1;
   assign req_stall = !adv_in;

   assign in_rows_in = '{req_row_0, req_row_1, req_row_2, req_row_3,
                         req_row_4, req_row_5, req_row_6, req_row_7};

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv_in) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in && req_valid) begin
         in_side_ff <= req_side_is_second;
         in_rows_ff <= in_rows_in;
      end
   end

   gsck_orient u_orient (
      .side (in_side_ff),
      .rows (in_rows_ff),
      .keys (cand)
   );

   gsck_reduce #(.IN_COUNT(N)) u_reduce1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv1),
      .in_valid  (in_valid_ff),
      .in_keys   (cand),
      .out_valid (lvl1_valid),
      .out_keys  (lvl1)
   );

   gsck_reduce #(.IN_COUNT(N/2)) u_reduce2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv2),
      .in_valid  (lvl1_valid),
      .in_keys   (lvl1),
      .out_valid (lvl2_valid),
      .out_keys  (lvl2)
   );

   // final compare doubles as the result register
   gsck_reduce #(.IN_COUNT(N/4)) u_reduce3 (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv3),
      .in_valid  (lvl2_valid),
      .in_keys   (lvl2),
      .out_valid (rsp_valid),
      .out_keys  (best)
   );

   assign rsp_key_low  = {best[0][3], best[0][2], best[0][1], best[0][0]};
   assign rsp_key_high = {best[0][7], best[0][6], best[0][5], best[0][4]};

endmodule

[hdl/gsck_orient.sv]
module gsck_orient (
   input  logic               side,
   input  gsck_pkg::row_type  rows [gsck_pkg::GRID_N],
   output gsck_pkg::key_type  keys [gsck_pkg::ORIENTS]
);

   gsck_pkg::cell_type grid [gsck_pkg::GRID_N][gsck_pkg::GRID_N];

   // normalize every cell
   always_comb begin
      for (int r = 0; r < gsck_pkg::GRID_N; r++) begin
         for (int c = 0; c < gsck_pkg::GRID_N; c++) begin
            grid[r][c] = gsck_pkg::norm_cell(
               rows[r][gsck_pkg::CELL_W*c +: gsck_pkg::CELL_W], side);
         end
      end
   end

   // the eight orientations are pure rewiring of the normalized grid
   always_comb begin
      logic [2*gsck_pkg::IDX_W-1:0] src;
      for (int k = 0; k < gsck_pkg::ORIENTS; k++) begin
         for (int i = 0; i < gsck_pkg::GRID_N; i++) begin
            for (int j = 0; j < gsck_pkg::GRID_N; j++) begin
               src = gsck_pkg::src_index(k, i, j);
               keys[k][i][gsck_pkg::CELL_W*j +: gsck_pkg::CELL_W] =
                  grid[src[2*gsck_pkg::IDX_W-1:gsck_pkg::IDX_W]]
                      [src[gsck_pkg::IDX_W-1:0]];
            end
         end
      end
   end

endmodule

[hdl/gsck_reduce.sv]
module gsck_reduce #(
   parameter int IN_COUNT = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  gsck_pkg::key_type in_keys  [IN_COUNT],
   output logic              out_valid,
   output gsck_pkg::key_type out_keys [IN_COUNT/2]
);

   localparam int OUT_COUNT = IN_COUNT / 2;

   logic              valid_ff;
   gsck_pkg::key_type keys_ff [OUT_COUNT];
   gsck_pkg::key_type keys_in [OUT_COUNT];

   // pairwise max; the lower index keeps a tie
   always_comb begin
      for (int p = 0; p < OUT_COUNT; p++) begin
         keys_in[p] = (in_keys[2*p+1] > in_keys[2*p]) ? in_keys[2*p+1] : in_keys[2*p];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         keys_ff <= keys_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_keys  = keys_ff;

endmodule

[hdl/gsck_checker.sv]
module gsck_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_key_low,
   input logic [63:0] rsp_key_high
);

   localparam logic [63:0] LOW_BITS = 64'h5555_5555_5555_5555;

   // a held result word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_low)
                                && $stable(rsp_key_high))
      else $error("stalled result word changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an open output slot drains the pipe, so the input never stalls
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || !rsp_stall |-> !req_stall)
      else $error("input stalled while output slot open");

   // blocked cells are cleared, so no cell of the key reads 3
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_key_low & (rsp_key_low >> 1) & LOW_BITS) == 64'd0)
                 && ((rsp_key_high & (rsp_key_high >> 1) & LOW_BITS) == 64'd0))
      else $error("key holds a blocked cell");

endmodule

bind grid_symmetry_canonical_key_top gsck_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_key_low  (rsp_key_low),
   .rsp_key_high (rsp_key_high)
);

[test/grid_symmetry_canonical_key_top_tb.sv]
`timescale 1ns / 1ps

module grid_symmetry_canonical_key_top_tb;

   localparam int STIM_ROWS   = 20;
   localparam int RAND_WORDS  = 750;
   localparam int HOLD_AT     = 150;   // result count at which the receiver holds off
   localparam int HOLD_CYCLES = 250;
   localparam int IDLE_LIMIT  = 2000;  // cycles without any handshake
   localparam int DRAIN_WAIT  = 12;

   // where a directed word takes its expected key from
   typedef enum bit {BY_PREDICTOR, BY_TABLE} check_kind_type;

   typedef struct packed {
      check_kind_type    kind;
      logic              side;
      logic [0:7][15:0]  rows;
      logic [63:0]       key_lo;
      logic [63:0]       key_hi;
   } grid_word_type;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
   } key_type;

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic        req_side_is_second = 1'b0;
   logic [15:0] req_row_0          = '0;
   logic [15:0] req_row_1          = '0;
   logic [15:0] req_row_2          = '0;
   logic [15:0] req_row_3          = '0;
   logic [15:0] req_row_4          = '0;
   logic [15:0] req_row_5          = '0;
   logic [15:0] req_row_6          = '0;
   logic [15:0] req_row_7          = '0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [63:0] rsp_key_low;
   logic [63:0] rsp_key_high;

   key_type expected_keys[$];
   key_type want;
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      no_idle     = 1'b0;

   grid_symmetry_canonical_key_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_side_is_second (req_side_is_second),
      .req_row_0          (req_row_0),
      .req_row_1          (req_row_1),
      .req_row_2          (req_row_2),
      .req_row_3          (req_row_3),
      .req_row_4          (req_row_4),
      .req_row_5          (req_row_5),
      .req_row_6          (req_row_6),
      .req_row_7          (req_row_7),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key_low        (rsp_key_low),
      .rsp_key_high       (rsp_key_high)
   );

   // directed words; rows listed row 0 first
   grid_word_type stim_table [STIM_ROWS] = '{
      // empty board
      '{BY_TABLE, 1'b0, {8{16'h0000}}, 64'h0, 64'h0},
      // every cell three reads empty, for either side
      '{BY_TABLE, 1'b0, {8{16'hFFFF}}, 64'h0, 64'h0},
      '{BY_TABLE, 1'b1, {8{16'hFFFF}}, 64'h0, 64'h0},
      // full boards of ones and twos, with and without the swap
      '{BY_TABLE, 1'b0, {8{16'h5555}}, {4{16'h5555}}, {4{16'h5555}}},
      '{BY_TABLE, 1'b1, {8{16'h5555}}, {4{16'hAAAA}}, {4{16'hAAAA}}},
      '{BY_TABLE, 1'b0, {8{16'hAAAA}}, {4{16'hAAAA}}, {4{16'hAAAA}}},
      '{BY_TABLE, 1'b1, {8{16'hAAAA}}, {4{16'h5555}}, {4{16'h5555}}},
      // single corner cell moves to row 0, column 7
      '{BY_TABLE, 1'b0, {16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h4000},
        64'h4000, 64'h0},
      '{BY_TABLE, 1'b1, {16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        64'h8000, 64'h0},
      // single center cell lands in row 3, column 4
      '{BY_TABLE, 1'b0, {16'h0, 16'h0, 16'h0, 16'h0080, 16'h0, 16'h0, 16'h0, 16'h0},
        64'h0200_0000_0000_0000, 64'h0},
      // lone three stays empty under the swap
      '{BY_TABLE, 1'b1, {16'h0003, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
        64'h0, 64'h0},
      '{BY_PREDICTOR, 1'b0, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                             16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3}, 64'h0, 64'h0},
      '{BY_PREDICTOR, 1'b1, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                             16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3}, 64'h0, 64'h0},
      '{BY_PREDICTOR, 1'b0, {16'h6666, 16'h9999, 16'h6666, 16'h9999,
                             16'h6666, 16'h9999, 16'h6666, 16'h9999}, 64'h0, 64'h0},
      '{BY_PREDICTOR, 1'b0, {16'hFFFF, {7{16'h5555}}}, 64'h0, 64'h0},
      '{BY_PREDICTOR, 1'b1, {{7{16'h0000}}, 16'hAAAA}, 64'h0, 64'h0},
      // diagonals
      '{BY_PREDICTOR, 1'b0, {16'h0001, 16'h0004, 16'h0010, 16'h0040,
                             16'h0100, 16'h0400, 16'h1000, 16'h4000}, 64'h0, 64'h0},
      '{BY_PREDICTOR, 1'b1, {16'h8000, 16'h2000, 16'h0800, 16'h0200,
                             16'h0080, 16'h0020, 16'h0008, 16'h0002}, 64'h0, 64'h0},
      // opening position, both sides to move
      '{BY_PREDICTOR, 1'b0, {16'h0, 16'h0, 16'h0, 16'h0180, 16'h0240, 16'h0, 16'h0, 16'h0},
        64'h0, 64'h0},
      '{BY_PREDICTOR, 1'b1, {16'h0, 16'h0, 16'h0, 16'h0180, 16'h0240, 16'h0, 16'h0, 16'h0},
        64'h0, 64'h0}
   };

   // canonical key: normalize cells, try all eight symmetries, keep the largest.
   // Symmetry t: bit 2 transposes, bit 1 flips rows, bit 0 flips columns.
   function automatic key_type canon_key(logic side, logic [0:7][15:0] rows);
      logic [1:0]       cells [8][8];
      logic [0:7][15:0] best;   // row 0 in the top bits: numeric order is row order
      logic [0:7][15:0] cand;
      logic [1:0]       v;
      int               si;
      int               sj;
      key_type          k;
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            v = rows[i][2*j +: 2];
            if (v == 2'd3) begin
               v = 2'd0;
            end else if (side && v != 2'd0) begin
               v = 2'd3 - v;
            end
            cells[i][j] = v;
         end
      end
      best = '0;
      for (int t = 0; t < 8; t++) begin
         cand = '0;
         for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
               si = (t & 4) ? j : i;
               sj = (t & 4) ? i : j;
               if (t & 2) si = 7 - si;
               if (t & 1) sj = 7 - sj;
               cand[i][2*j +: 2] = cells[si][sj];
            end
         end
         if (cand > best) best = cand;
      end
      k.lo = {best[3], best[2], best[1], best[0]};
      k.hi = {best[7], best[6], best[5], best[4]};
      return k;
   endfunction

   // random board: uniform bits, sparse, mirrored (ties), or game-like cells
   function automatic grid_word_type random_word();
      grid_word_type w;
      grid_word_type src;
      int            mode;
      int            sym;
      w      = '0;
      w.kind = BY_PREDICTOR;
      w.side = 1'($urandom_range(0, 1));
      mode   = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++) begin
         if (mode < 2) begin
            w.rows[i] = 16'($urandom);
         end else begin
            for (int j = 0; j < 8; j++) begin
               if (mode < 4) begin
                  w.rows[i][2*j +: 2] = ($urandom_range(0, 7) == 0) ?
                                        2'($urandom_range(1, 3)) : 2'd0;
               end else if (mode < 6) begin
                  w.rows[i][2*j +: 2] = 2'($urandom_range(0, 3));
               end else begin
                  w.rows[i][2*j +: 2] = 2'($urandom_range(0, 2));
               end
            end
         end
      end
      if (mode == 4 || mode == 5) begin
         src = w;
         sym = $urandom_range(0, 2);
         for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
               if (sym == 0 && j > 3) begin
                  w.rows[i][2*j +: 2] = src.rows[i][2*(7-j) +: 2];
               end else if (sym == 1 && i > 3) begin
                  w.rows[i][2*j +: 2] = src.rows[7-i][2*j +: 2];
               end else if (sym == 2 && j > i) begin
                  w.rows[i][2*j +: 2] = src.rows[j][2*i +: 2];
               end
            end
         end
      end
      return w;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 15);
   endfunction

   // present one word, hold it until taken, then record its key
   task automatic offer(grid_word_type w);
      int      gap;
      bit      taken;
      key_type k;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_side_is_second <= w.side;
      req_row_0          <= w.rows[0];
      req_row_1          <= w.rows[1];
      req_row_2          <= w.rows[2];
      req_row_3          <= w.rows[3];
      req_row_4          <= w.rows[4];
      req_row_5          <= w.rows[5];
      req_row_6          <= w.rows[6];
      req_row_7          <= w.rows[7];
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         @(posedge clock);
      end
      if (w.kind == BY_TABLE) begin
         k.lo = w.key_lo;
         k.hi = w.key_hi;
      end else begin
         k = canon_key(w.side, w.rows);
      end
      expected_keys.push_back(k);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // stimulus: directed table, then random boards
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < STIM_ROWS; n++) begin
         offer(stim_table[n]);
      end
      for (int n = 0; n < RAND_WORDS; n++) begin
         if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         offer(random_word());
      end
      req_valid <= 1'b0;
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // receiver: random stalls, one long hold-off so the pipe backs up
   initial begin
      int gap;
      int taken_count;
      bit got;
      taken_count = 0;
      while (reset) @(posedge clock);
      forever begin
         gap = (taken_count == HOLD_AT) ? HOLD_CYCLES : draw_gap();
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         got = 1'b0;
         while (!got) begin
            @(negedge clock);
            got = (rsp_valid === 1'b1);
            @(posedge clock);
         end
         taken_count++;
      end
   end

   // compare each taken result with the oldest expected key
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_keys.size() == 0) begin
            $error("unexpected result word: key_low=%h key_high=%h", rsp_key_low, rsp_key_high);
            error_count++;
         end else begin
            want = expected_keys.pop_front();
            if (rsp_key_low !== want.lo) begin
               $error("key_low: expected %h, got %h", want.lo, rsp_key_low);
               error_count++;
            end
            if (rsp_key_high !== want.hi) begin
               $error("key_high: expected %h, got %h", want.hi, rsp_key_high);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(negedge clock) begin
      if (!reset) begin
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

endmodule

[grid_symmetry_canonical_key_top.f]
hdl/gsck_pkg.sv
hdl/gsck_orient.sv
hdl/gsck_reduce.sv
hdl/grid_symmetry_canonical_key_top.sv
hdl/gsck_checker.sv
test/grid_symmetry_canonical_key_top_tb.sv
